// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion with an active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- rtl/core/ttws_pkg.sv -----
// Package of types, constants and the sine table for the texture warp shader.
package ttws_pkg;
  localparam int TEX_LG     = 6;
  localparam int SINE_LG    = 7;
  localparam int COORD_BITS = 10;
  localparam int FRAC       = 8;
  localparam int POS_W      = SINE_LG + FRAC;
  localparam int WRAP_W     = TEX_LG + FRAC;
  localparam int BANK_AW    = 2 * (TEX_LG - 1);
  localparam int ROM_W      = 13;
  localparam int IDX_W      = 12;
  localparam int VAL_W      = 24;

  typedef enum logic [1:0] {
    REQ_TEXEL   = 2'd0,
    REQ_PALETTE = 2'd1,
    REQ_SHADE   = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef struct packed {
    logic              valid;
    req_t              req;
    logic [IDX_W-1:0]  idx;
    logic [VAL_W-1:0]  value;
  } ctl_t;

  localparam logic [11:0] QUARTER [33] = '{
    12'd0, 12'd128, 12'd255, 12'd382, 12'd508, 12'd632, 12'd755, 12'd877,
    12'd996, 12'd1112, 12'd1227, 12'd1338, 12'd1446, 12'd1550, 12'd1651,
    12'd1747, 12'd1840, 12'd1928, 12'd2011, 12'd2090, 12'd2163, 12'd2232,
    12'd2295, 12'd2352, 12'd2404, 12'd2450, 12'd2490, 12'd2524, 12'd2552,
    12'd2574, 12'd2589, 12'd2599, 12'd2602
  };

  // Scaled sine entry for table index 0..period, built from the quarter wave.
  function automatic logic signed [ROM_W-1:0] sine_entry(input logic [SINE_LG:0] i);
    logic [6:0]  k;
    logic [11:0] mag;
    k = 7'((int'(i) * 128) >> SINE_LG);
    if (k <= 7'd32)      mag = QUARTER[k[5:0]];
    else if (k <= 7'd64) mag = QUARTER[6'(7'd64 - k)];
    else if (k <= 7'd96) mag = QUARTER[6'(k - 7'd64)];
    else                 mag = QUARTER[6'(8'd128 - {1'b0, k})];
    if (k > 7'd64) sine_entry = -$signed({1'b0, mag});
    else           sine_entry = $signed({1'b0, mag});
  endfunction
endpackage

// ----- rtl/core/ttws_tex_bank.sv -----
// One quarter bank of the heat texture: one write port and one registered read port.
module ttws_tex_bank (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        we,
  input  logic [ttws_pkg::BANK_AW-1:0] waddr,
  input  logic [7:0]                  wdata,
  input  logic [ttws_pkg::BANK_AW-1:0] raddr,
  output logic [7:0]                  rdata_r
);
  import ttws_pkg::*;

  logic [7:0] mem [1 << BANK_AW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[waddr] <= wdata;
      rdata_r <= mem[raddr];
    end
  end
endmodule

// ----- rtl/core/turbulent_texture_warp_shader.sv -----
// Top level of the turbulent texture warp shader pipeline.
// Usage: one input stream carries three kinds of transaction, selected by
// in_tuser: a texel write, a palette write and a shade request. Only a
// shade request produces an output transaction, the RGB color of the cell.
// Writes take effect in stream order, so a shade request sees every write
// that was accepted before it and none accepted after it.
// Throughput is one transaction per cycle while the receiver does not stall;
// the eight register stages are the input register, sine lookup,
// interpolation, coordinate wrap, texture read, horizontal blend, vertical
// blend and rounding, and palette read into the output register. Four
// texels are fetched per cycle from four texture banks split by row and
// column parity, each with one read port.
// When the receiver stalls, the whole pipeline holds in place and
// in_tready drops; nothing is lost or repeated. Reset (rst_n low,
// synchronous) clears all stage valid bits; texture and palette contents
// are not cleared and must be written before they are read.
module turbulent_texture_warp_shader (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: table_index[11:0], write_value[35:12], cell_row[45:36],
  // cell_column[55:46], phase[70:56], zero[71]
  input  logic [71:0] in_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: red[7:0], green[15:8], blue[23:16]
  output logic [23:0] out_tdata
);
  import ttws_pkg::*;
  `include "assert_macros.svh"

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: input register.
  ctl_t                  s1_ctl_r;
  logic [COORD_BITS-1:0] s1_row_r, s1_col_r;
  logic [POS_W-1:0]      s1_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_ctl_r.valid <= 1'b0;
    else if (en) s1_ctl_r.valid <= in_tvalid;
    if (en) begin
      s1_ctl_r.req   <= req_t'(in_tuser);
      s1_ctl_r.idx   <= in_tdata[11:0];
      s1_ctl_r.value <= in_tdata[35:12];
      s1_row_r       <= in_tdata[45:36];
      s1_col_r       <= in_tdata[55:46];
      s1_phase_r     <= in_tdata[70:56];
    end
  end

  // Stage 2: table positions and sine lookups.
  logic [POS_W-1:0] rpos, cpos;
  assign rpos = s1_phase_r + {s1_row_r[SINE_LG-2:0], 1'b0, {FRAC{1'b0}}};
  assign cpos = s1_phase_r + {s1_col_r[SINE_LG-1:0], {FRAC{1'b0}}};

  ctl_t                    s2_ctl_r;
  logic signed [ROM_W-1:0] s2_r0_r, s2_r1_r, s2_c0_r, s2_c1_r;
  logic [FRAC-1:0]         s2_rf_r, s2_cf_r;
  logic [TEX_LG-1:0]       s2_col_r;
  logic [TEX_LG-2:0]       s2_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_ctl_r.valid <= 1'b0;
    else if (en) s2_ctl_r.valid <= s1_ctl_r.valid;
    if (en) begin
      s2_ctl_r.req   <= s1_ctl_r.req;
      s2_ctl_r.idx   <= s1_ctl_r.idx;
      s2_ctl_r.value <= s1_ctl_r.value;
      s2_r0_r  <= sine_entry({1'b0, rpos[POS_W-1:FRAC]});
      s2_r1_r  <= sine_entry({1'b0, rpos[POS_W-1:FRAC]} + 1'b1);
      s2_c0_r  <= sine_entry({1'b0, cpos[POS_W-1:FRAC]});
      s2_c1_r  <= sine_entry({1'b0, cpos[POS_W-1:FRAC]} + 1'b1);
      s2_rf_r  <= rpos[FRAC-1:0];
      s2_cf_r  <= cpos[FRAC-1:0];
      s2_col_r <= s1_col_r[TEX_LG-1:0];
      s2_row_r <= s1_row_r[TEX_LG-2:0];
    end
  end

  // Stage 3: linear interpolation of both shifts, rounded to 8 fraction bits.
  logic signed [FRAC+1:0] rw1, rw0, cw1, cw0;
  logic signed [23:0]     racc, cacc;
  assign rw1  = $signed({2'b00, s2_rf_r});
  assign rw0  = $signed(10'd256) - rw1;
  assign cw1  = $signed({2'b00, s2_cf_r});
  assign cw0  = $signed(10'd256) - cw1;
  assign racc = s2_r0_r * rw0 + s2_r1_r * rw1 + 24'sd128;
  assign cacc = s2_c0_r * cw0 + s2_c1_r * cw1 + 24'sd128;

  ctl_t                    s3_ctl_r;
  logic signed [ROM_W-1:0] s3_rsh_r, s3_csh_r;
  logic [TEX_LG-1:0]       s3_col_r;
  logic [TEX_LG-2:0]       s3_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_ctl_r.valid <= 1'b0;
    else if (en) s3_ctl_r.valid <= s2_ctl_r.valid;
    if (en) begin
      s3_ctl_r.req   <= s2_ctl_r.req;
      s3_ctl_r.idx   <= s2_ctl_r.idx;
      s3_ctl_r.value <= s2_ctl_r.value;
      s3_rsh_r <= racc[ROM_W+FRAC-1:FRAC];
      s3_csh_r <= cacc[ROM_W+FRAC-1:FRAC];
      s3_col_r <= s2_col_r;
      s3_row_r <= s2_row_r;
    end
  end

  // Stage 4: wrapped texture coordinates and bank addresses.
  logic [WRAP_W-1:0]  ws, wt;
  logic [TEX_LG-1:0]  s0, s1, t0, t1;
  assign ws = {s3_col_r, {FRAC{1'b0}}} + WRAP_W'(s3_rsh_r);
  assign wt = {s3_row_r, 1'b0, {FRAC{1'b0}}} + WRAP_W'(s3_csh_r);
  assign s0 = ws[WRAP_W-1:FRAC];
  assign t0 = wt[WRAP_W-1:FRAC];
  assign s1 = s0 + 1'b1;
  assign t1 = t0 + 1'b1;

  ctl_t                 s4_ctl_r;
  logic [BANK_AW-1:0]   s4_addr_r [4];
  logic                 s4_sp_r, s4_tp_r;
  logic [FRAC-1:0]      s4_fs_r, s4_ft_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_ctl_r.valid <= 1'b0;
    else if (en) s4_ctl_r.valid <= s3_ctl_r.valid;
    if (en) begin
      s4_ctl_r.req   <= s3_ctl_r.req;
      s4_ctl_r.idx   <= s3_ctl_r.idx;
      s4_ctl_r.value <= s3_ctl_r.value;
      // Bank index is {row parity, column parity}.
      for (int b = 0; b < 4; b++) begin
        s4_addr_r[b] <= {((t0[0] == b[1]) ? t0[TEX_LG-1:1] : t1[TEX_LG-1:1]),
                         ((s0[0] == b[0]) ? s0[TEX_LG-1:1] : s1[TEX_LG-1:1])};
      end
      s4_sp_r <= s0[0];
      s4_tp_r <= t0[0];
      s4_fs_r <= ws[FRAC-1:0];
      s4_ft_r <= wt[FRAC-1:0];
    end
  end

  // Stage 5: texture banks; texel writes land here in stream order.
  logic [7:0]          bank_q [4];
  logic [TEX_LG-1:0]   w_row, w_col;
  logic                tex_we;
  assign w_row  = s4_ctl_r.idx[2*TEX_LG-1:TEX_LG];
  assign w_col  = s4_ctl_r.idx[TEX_LG-1:0];
  assign tex_we = s4_ctl_r.valid && (s4_ctl_r.req == REQ_TEXEL);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    ttws_tex_bank u_bank (
      .clk     (clk),
      .en      (en),
      .we      (tex_we && (w_row[0] == 1'(b >> 1)) && (w_col[0] == 1'(b))),
      .waddr   ({w_row[TEX_LG-1:1], w_col[TEX_LG-1:1]}),
      .wdata   (s4_ctl_r.value[7:0]),
      .raddr   (s4_addr_r[b]),
      .rdata_r (bank_q[b])
    );
  end

  ctl_t            s5_ctl_r;
  logic            s5_sp_r, s5_tp_r;
  logic [FRAC-1:0] s5_fs_r, s5_ft_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_ctl_r.valid <= 1'b0;
    else if (en) s5_ctl_r.valid <= s4_ctl_r.valid;
    if (en) begin
      s5_ctl_r.req   <= s4_ctl_r.req;
      s5_ctl_r.idx   <= s4_ctl_r.idx;
      s5_ctl_r.value <= s4_ctl_r.value;
      s5_sp_r <= s4_sp_r;
      s5_tp_r <= s4_tp_r;
      s5_fs_r <= s4_fs_r;
      s5_ft_r <= s4_ft_r;
    end
  end

  // Stage 6: horizontal blend of the top and bottom texel pairs.
  logic [7:0] d00, d10, d01, d11;
  logic [8:0] hw1, hw0;
  assign d00 = bank_q[{s5_tp_r, s5_sp_r}];
  assign d10 = bank_q[{s5_tp_r, !s5_sp_r}];
  assign d01 = bank_q[{!s5_tp_r, s5_sp_r}];
  assign d11 = bank_q[{!s5_tp_r, !s5_sp_r}];
  assign hw1 = {1'b0, s5_fs_r};
  assign hw0 = 9'd256 - hw1;

  ctl_t            s6_ctl_r;
  logic [15:0]     s6_top_r, s6_bot_r;
  logic [FRAC-1:0] s6_ft_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_ctl_r.valid <= 1'b0;
    else if (en) s6_ctl_r.valid <= s5_ctl_r.valid;
    if (en) begin
      s6_ctl_r.req   <= s5_ctl_r.req;
      s6_ctl_r.idx   <= s5_ctl_r.idx;
      s6_ctl_r.value <= s5_ctl_r.value;
      s6_top_r <= 16'(d00) * 16'(hw0) + 16'(d10) * 16'(hw1);
      s6_bot_r <= 16'(d01) * 16'(hw0) + 16'(d11) * 16'(hw1);
      s6_ft_r  <= s5_ft_r;
    end
  end

  // Stage 7: vertical blend and round half up to the heat value.
  logic [8:0]  vw1, vw0;
  logic [23:0] vacc;
  assign vw1  = {1'b0, s6_ft_r};
  assign vw0  = 9'd256 - vw1;
  assign vacc = 24'(s6_top_r) * 24'(vw0) + 24'(s6_bot_r) * 24'(vw1) + 24'd32768;

  ctl_t       s7_ctl_r;
  logic [7:0] s7_heat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_ctl_r.valid <= 1'b0;
    else if (en) s7_ctl_r.valid <= s6_ctl_r.valid;
    if (en) begin
      s7_ctl_r.req   <= s6_ctl_r.req;
      s7_ctl_r.idx   <= s6_ctl_r.idx;
      s7_ctl_r.value <= s6_ctl_r.value;
      s7_heat_r <= vacc[23:16];
    end
  end

  // Stage 8: palette read straight into the output register.
  logic [VAL_W-1:0] palette [256];
  logic [VAL_W-1:0] color_r;
  logic             out_valid_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (s7_ctl_r.valid && (s7_ctl_r.req == REQ_PALETTE))
        palette[s7_ctl_r.idx[7:0]] <= s7_ctl_r.value;
      color_r <= palette[s7_heat_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= s7_ctl_r.valid && (s7_ctl_r.req == REQ_SHADE);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {color_r[7:0], color_r[15:8], color_r[23:16]};

  `ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid,
    "output valid after reset")
  `ASSERT_CLK(a_shade_reaches_out, clk, rst_n,
    (s7_ctl_r.valid && s7_ctl_r.req == REQ_SHADE && en) |=> out_tvalid,
    "shade request lost before output")
  `ASSERT_CLK(a_stall_holds_stage, clk, rst_n,
    (out_tvalid && !out_tready) |=> $stable(s7_ctl_r) && $stable(out_tdata),
    "pipeline moved during stall")
endmodule

// ----- sim/turbulent_texture_warp_shader_test.sv -----
// Self-checking testbench for the turbulent texture warp shader with a built-in color predictor.
module turbulent_texture_warp_shader_test;
  import ttws_pkg::*;

  typedef struct packed {
    req_t        kind;
    logic [11:0] index;
    logic [23:0] value;
    logic [9:0]  row;
    logic [9:0]  column;
    logic [14:0] phase;
  } shade_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  turbulent_texture_warp_shader DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Predictor state: texture, palette and the scaled sine table.
  logic [7:0]         heat_map [4096];
  logic [23:0]        palette_rgb [256];
  bit                 heat_known [4096];
  bit                 palette_known [256];
  int                 sine_tab [129];
  shade_req_t         pending_reqs[$];
  logic [23:0]        expected_colors[$];
  int                 mismatches;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  bit                 hold_sender;

  localparam int QW [33] = '{0, 128, 255, 382, 508, 632, 755, 877, 996, 1112, 1227, 1338,
    1446, 1550, 1651, 1747, 1840, 1928, 2011, 2090, 2163, 2232, 2295, 2352, 2404, 2450,
    2490, 2524, 2552, 2574, 2589, 2599, 2602};

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic int warp_offset(input int ph, input int offs);
    int p;
    int i;
    int f;
    int acc;
    p = (ph + (offs << 8)) % 32768;
    i = p >> 8;
    f = p & 255;
    acc = sine_tab[i] * (256 - f) + sine_tab[i + 1] * f + 128;
    return (acc + (1 << 24)) / 256 - (1 << 16);
  endfunction

  // Returns the four texel addresses and the blend fractions of one cell.
  function automatic void cell_taps(input shade_req_t r, output int adr [4], output int fs,
                                    output int ft);
    int rs, cs, ws, wt, s0, t0, s1, t1;
    rs = warp_offset(r.phase, 2 * r.row);
    cs = warp_offset(r.phase, r.column);
    ws = ((r.column << 8) + rs) & 16383;
    wt = (((2 * r.row) << 8) + cs) & 16383;
    s0 = ws >> 8; t0 = wt >> 8; fs = ws & 255; ft = wt & 255;
    s1 = (s0 + 1) & 63; t1 = (t0 + 1) & 63;
    adr[0] = (t0 * 64 + s0) & 4095; adr[1] = (t0 * 64 + s1) & 4095;
    adr[2] = (t1 * 64 + s0) & 4095; adr[3] = (t1 * 64 + s1) & 4095;
  endfunction

  function automatic int blended_heat(input shade_req_t r);
    int adr [4];
    int fs, ft;
    longint top, bot, acc;
    cell_taps(r, adr, fs, ft);
    top = heat_map[adr[0]] * (256 - fs) + heat_map[adr[1]] * fs;
    bot = heat_map[adr[2]] * (256 - fs) + heat_map[adr[3]] * fs;
    acc = top * (256 - ft) + bot * ft;
    return int'((acc + 32768) >> 16) & 255;
  endfunction

  // A shade is legal only if all four taps and the resulting palette entry
  // have been written.
  function automatic bit shade_is_safe(input shade_req_t r);
    int adr [4];
    int fs, ft;
    cell_taps(r, adr, fs, ft);
    for (int k = 0; k < 4; k++) if (!heat_known[adr[k]]) return 0;
    return palette_known[blended_heat(r)];
  endfunction

  // Applies one accepted transaction to the predictor.
  task automatic predict_color(input shade_req_t r);
    case (r.kind)
      REQ_TEXEL: if (r.index < 4096) heat_map[r.index] = r.value[7:0];
      REQ_PALETTE: palette_rgb[r.index[7:0]] = r.value;
      REQ_SHADE: begin
        logic [23:0] c;
        c = palette_rgb[blended_heat(r)];
        expected_colors.push_back({c[7:0], c[15:8], c[23:16]});
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // Queues an item, dropping unsafe shades, and tracks which entries become readable for later shades.
  task automatic queue_req(input shade_req_t r);
    if (r.kind == REQ_SHADE && !shade_is_safe(r)) return;
    if (r.kind == REQ_TEXEL) heat_known[r.index] = 1;
    if (r.kind == REQ_PALETTE) palette_known[r.index[7:0]] = 1;
    pending_reqs.push_back(r);
  endtask

  function automatic shade_req_t rand_req(input req_t k);
    shade_req_t r;
    r.kind = k;
    r.index = 12'($urandom);
    r.value = 24'($urandom);
    r.row = 10'($urandom);
    r.column = 10'($urandom);
    r.phase = 15'($urandom);
    return r;
  endfunction

  // Draws random cells, up to 1000 tries, until one reads only written texture and palette entries.
  function automatic shade_req_t safe_shade();
    shade_req_t r;
    r = rand_req(REQ_SHADE);
    for (int n = 0; n < 1000 && !shade_is_safe(r); n++) r = rand_req(REQ_SHADE);
    return r;
  endfunction

  // Driver: presents the head of the queue, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_color(pending_reqs.pop_front());
      end
      if ((!in_tvalid || in_tready) ) begin
        if (pending_reqs.size() > (in_tvalid && in_tready ? 0 : 0) && !hold_sender &&
            pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_reqs[0].kind;
          in_tdata  <= {1'b0, pending_reqs[0].phase, pending_reqs[0].column,
                        pending_reqs[0].row, pending_reqs[0].value, pending_reqs[0].index};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output transaction against the oldest expected color.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_colors.size() == 0) begin
          report_mismatch("unexpected", out_tdata, 24'h0);
        end else begin
          logic [23:0] want;
          want = expected_colors.pop_front();
          if (out_tdata[7:0] != want[7:0]) report_mismatch("red", out_tdata, want);
          if (out_tdata[15:8] != want[15:8]) report_mismatch("green", out_tdata, want);
          if (out_tdata[23:16] != want[23:16]) report_mismatch("blue", out_tdata, want);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || expected_colors.size() != 0)
      @(posedge clk);
  endtask

  // Sends a random mix of texel writes, palette writes, no-op requests and shades of random cells.
  task automatic run_phase(input int count, input int idle, input int stall);
    shade_req_t r;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0: r = rand_req(REQ_TEXEL);
        1: r = rand_req(REQ_PALETTE);
        2: r = rand_req(REQ_NONE);
        default: r = safe_shade();
      endcase
      queue_req(r);
      while (pending_reqs.size() > 8) @(posedge clk);
    end
    wait_drained();
  endtask

  initial begin
    shade_req_t r;
    mismatches = 0;
    hold_sender = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_NONE;
    out_tready = 1'b0;
    for (int i = 0; i <= 128; i++) begin
      int k;
      k = i & 127;
      if (k <= 32) sine_tab[i] = QW[k];
      else if (k <= 64) sine_tab[i] = QW[64 - k];
      else if (k <= 96) sine_tab[i] = -QW[k - 64];
      else sine_tab[i] = -QW[128 - k];
    end
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme values and every request kind.
    // The first eight texture rows are loaded; shades are drawn to read only those.
    for (int i = 0; i < 512; i++) begin
      r = rand_req(REQ_TEXEL);
      r.index = 12'(i);
      r.value = (i % 7 == 0) ? 24'hFFFFFF : ((i % 5 == 0) ? 24'h0 : r.value);
      queue_req(r);
      while (pending_reqs.size() > 8) @(posedge clk);
    end
    for (int i = 0; i < 256; i++) begin
      r = rand_req(REQ_PALETTE);
      r.index = {4'($urandom_range(15)), i[7:0]};
      if (i == 0) r.value = 24'h000000;
      if (i == 255) r.value = 24'hFFFFFF;
      queue_req(r);
      while (pending_reqs.size() > 8) @(posedge clk);
    end
    r = rand_req(REQ_SHADE);
    r.row = 0; r.column = 0; r.phase = 0; queue_req(r);
    r.row = 10'h3FF; r.column = 10'h3FF; r.phase = 15'h7FFF; queue_req(r);
    r.row = 0; r.column = 10'h3FF; r.phase = 15'h4000; queue_req(r);
    r = rand_req(REQ_NONE); queue_req(r);
    r = safe_shade(); queue_req(r);
    wait_drained();

    // Sender pauses until every expected color has arrived, then carries on.
    for (int n = 0; n < 8; n++) queue_req(safe_shade());
    while (pending_reqs.size() > 4) @(posedge clk);
    hold_sender = 1'b1;
    while (in_tvalid || expected_colors.size() != 0) @(posedge clk);
    hold_sender = 1'b0;
    wait_drained();

    run_phase(130, 0, 0);
    run_phase(120, 88, 0);
    run_phase(120, 0, 88);
    run_phase(100, 6, 6);

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_colors.size() == 0) begin
      $display("PASS turbulent_texture_warp_shader");
    end else begin
      $display("FAIL turbulent_texture_warp_shader");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL turbulent_texture_warp_shader");
    $finish;
  end
endmodule
